[rtl/simd_vector_permute_unit_top_macros.svh]
// Assertion macros for the vector permute unit top level.
// Included by simd_vector_permute_unit_top; no other dependencies.
`ifndef SIMD_VECTOR_PERMUTE_UNIT_TOP_MACROS_SVH
`define SIMD_VECTOR_PERMUTE_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SVPU_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("svpu check failed");
`define SVPU_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("svpu check failed");
`else
`define SVPU_ASSERT_IMPL(label, a, c)
`define SVPU_ASSERT_NEXT(label, a, c)
`endif
`endif

[rtl/svpu_pkg.sv]
// Package for the vector permute unit: operation codes and shared types.
// No dependencies.
`default_nettype none
package svpu_pkg;
    typedef enum logic [4:0] {
        OP_PSHUFB = 5'd0, OP_UNPCKL = 5'd1, OP_UNPCKH = 5'd2, OP_PSHUFD = 5'd3,
        OP_PSHUFLW = 5'd4, OP_PSHUFHW = 5'd5, OP_SHUFPS = 5'd6, OP_SHUFPD = 5'd7,
        OP_PALIGNR = 5'd8, OP_BLENDD = 5'd9, OP_PERM2F = 5'd10, OP_MOVDDUP = 5'd11,
        OP_MOVSHDUP = 5'd12, OP_MOVSLDUP = 5'd13, OP_PSHUFW = 5'd14,
        OP_BCAST = 5'd15, OP_PERMD = 5'd16
    } op_t;

    localparam int LANE_BYTES = 16;
    localparam logic [7:0] MAX_SHIFT = 8'd32;

    typedef logic [7:0] byte_t;
    typedef byte_t [LANE_BYTES-1:0] lane_t;

    // Control shared by both lanes
    typedef struct packed {
        logic [4:0] op;
        logic [7:0] imm;
        logic [1:0] elog;
        logic       wide;
    } ctrl_t;
endpackage
`default_nettype wire

[rtl/svpu_lane.sv]
// One 128-bit lane of the permute datapath (in-lane and cross-lane operations).
// Depends on svpu_pkg.
`default_nettype none
module svpu_lane
    import svpu_pkg::*;
(
    input  wire  logic  lane_idx,
    input  wire  ctrl_t ctrl,
    input  wire  lane_t a,
    input  wire  lane_t b,
    input  wire  lane_t a_full_lo,
    input  wire  lane_t a_full_hi,
    input  wire  lane_t b_full_lo,
    input  wire  lane_t b_full_hi,
    output lane_t r
);
    always_comb
    begin
        logic [3:0] es;
        logic [7:0] sh;
        logic [5:0] idx;
        logic [3:0] c;
        logic [3:0] rel;
        logic [3:0] e;
        logic       hi;
        logic [2:0] d;
        logic [1:0] sel;
        logic [7:0] dsel;
        r    = '0;
        idx  = '0;
        c    = '0;
        rel  = '0;
        e    = '0;
        hi   = 1'b0;
        d    = '0;
        sel  = '0;
        dsel = '0;
        es = 4'd1 << ctrl.elog;
        sh = (ctrl.imm > MAX_SHIFT) ? MAX_SHIFT : ctrl.imm;
        for (int j = 0; j < 16; j++)
        begin
            case (ctrl.op)
                OP_PSHUFB:  r[j] = b[j][7] ? 8'd0 : a[b[j][3:0]];
                OP_UNPCKL, OP_UNPCKH:
                begin
                    // element index e = j/es, byte within = j%es
                    case (ctrl.elog)
                        2'd0: e = 4'(j);
                        2'd1: e = 4'(j >> 1);
                        2'd2: e = 4'(j >> 2);
                        default: e = 4'(j >> 3);
                    endcase
                    rel = 4'(j) & (es - 4'd1);
                    hi  = (ctrl.op == OP_UNPCKH);
                    // source element = (hb + e/2)
                    case (ctrl.elog)
                        2'd0: idx = 6'({hi, 3'(e >> 1)});
                        2'd1: idx = 6'({hi, 2'(e >> 1), 1'b0} | rel);
                        2'd2: idx = 6'({hi, 1'(e >> 1), 2'b0} | rel);
                        default: idx = 6'({hi, 3'b0} | rel);
                    endcase
                    r[j] = e[0] ? b[idx[3:0]] : a[idx[3:0]];
                end
                OP_PSHUFD:  r[j] = a[{ctrl.imm[2*(j/4)+:2], 2'(j % 4)}];
                OP_PSHUFLW: r[j] = (j < 8) ?
                    a[{1'b0, ctrl.imm[2*(j/2)+:2], 1'(j % 2)}] : a[j];
                OP_PSHUFHW: r[j] = (j < 8) ? a[j] :
                    a[{1'b1, ctrl.imm[2*((j-8)/2)+:2], 1'(j % 2)}];
                OP_SHUFPS:  r[j] = (j < 8) ? a[{ctrl.imm[2*(j/4)+:2], 2'(j % 4)}]
                                           : b[{ctrl.imm[2*(j/4)+:2], 2'(j % 4)}];
                OP_SHUFPD:  r[j] = (j < 8) ?
                    a[{ctrl.imm[{lane_idx, 1'b0}], 3'(j % 8)}] :
                    b[{ctrl.imm[{lane_idx, 1'b1}], 3'(j % 8)}];
                OP_PALIGNR:
                begin
                    idx = 6'(j) + sh[5:0];
                    if (idx < 6'd16) r[j] = b[idx[3:0]];
                    else if (idx < 6'd32) r[j] = a[idx[3:0]];
                    else r[j] = 8'd0;
                end
                OP_BLENDD:
                begin
                    d = {lane_idx, 2'(j / 4)};
                    r[j] = ctrl.imm[d] ? b[j] : a[j];
                end
                OP_PERM2F:
                begin
                    c = lane_idx ? ctrl.imm[7:4] : ctrl.imm[3:0];
                    case (c[1:0])
                        2'd0: r[j] = a_full_lo[j];
                        2'd1: r[j] = a_full_hi[j];
                        2'd2: r[j] = b_full_lo[j];
                        default: r[j] = b_full_hi[j];
                    endcase
                    if (c[3] || !ctrl.wide) r[j] = 8'd0;
                end
                OP_MOVDDUP:  r[j] = a[j % 8];
                OP_MOVSHDUP: r[j] = a[{1'(j / 8), 1'b1, 2'(j % 4)}];
                OP_MOVSLDUP: r[j] = a[{1'(j / 8), 1'b0, 2'(j % 4)}];
                OP_PSHUFW:   r[j] = (j < 8 && !lane_idx && !ctrl.wide) ?
                    a[{1'b0, ctrl.imm[2*(j/2)+:2], 1'(j % 2)}] : 8'd0;
                OP_BCAST:    r[j] = a_full_lo[4'(j) & (es - 4'd1)];
                OP_PERMD:
                begin
                    dsel = a[(j/4)*4];
                    sel  = dsel[1:0];
                    r[j] = dsel[2] ? b_full_hi[{sel, 2'(j % 4)}]
                                   : b_full_lo[{sel, 2'(j % 4)}];
                    if (!ctrl.wide) r[j] = 8'd0;
                end
                default: r[j] = 8'd0;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/svpu_merge.sv]
// Merging stage: joins lane results, applies width and support masking.
// Depends on svpu_pkg.
`default_nettype none
module svpu_merge
    import svpu_pkg::*;
(
    input  wire  ctrl_t       ctrl,
    input  wire  lane_t       r_lo,
    input  wire  lane_t       r_hi,
    output logic [255:0]      res,
    output logic              ok
);
    always_comb
    begin
        ok = 1'b1;
        if (ctrl.op > OP_PERMD) ok = 1'b0;
        if ((ctrl.op == OP_PERM2F || ctrl.op == OP_PERMD) && !ctrl.wide) ok = 1'b0;
        if (ctrl.op == OP_PSHUFW && ctrl.wide) ok = 1'b0;
        res = ok ? {(ctrl.wide ? r_hi : lane_t'('0)), r_lo} : 256'd0;
    end
endmodule
`default_nettype wire

[rtl/simd_vector_permute_unit_top.sv]
// Top level of the vector permute unit: two lane datapaths, merge, output register.
// Depends on svpu_pkg, svpu_lane, svpu_merge and the macros header.
//
// Usage:
//   Slave channel s_axis_*: one transaction is one permute request.
//   Master channel m_axis_*: one transaction per request, in order.
//   Two lane datapaths compute the low and high 128-bit halves side by side;
//   the merge stage masks unsupported forms and the narrow upper half, then
//   the result lands in an output register.
//   The result is registered; m_axis_tvalid is high in the cycle after acceptance.
//   Throughput: 1 transaction per cycle while m_axis_tready stays high, set by
//   the single output register whose ready passes through combinationally.
//   Reset: rst_n asynchronous low empties the output register.
//   Stall: while m_axis_tready is low and a result waits, hold it and drop
//   s_axis_tready; a fresh transaction is taken in the same cycle the held
//   one is taken.
`default_nettype none
`include "simd_vector_permute_unit_top_macros.svh"
module simd_vector_permute_unit_top
    import svpu_pkg::*;
(
    input  wire  logic         clk,
    input  wire  logic         rst_n,
    input  wire  logic         s_axis_tvalid,
    output logic               s_axis_tready,
    // a_w0..a_w3, b_w0..b_w3, imm_ctrl[519:512], req_type[524:520],
    // elem_log2[526:525], is_wide[527]
    input  wire  logic [527:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire  logic         m_axis_tready,
    // res_w0..res_w3 [255:0], handled [256], zero pad
    output logic [263:0]       m_axis_tdata
);
    ctrl_t  ctrl;
    lane_t  a_lo, a_hi, b_lo, b_hi, r_lo, r_hi;
    logic [255:0] res;
    logic   ok;
    logic   valid_reg, valid_next;
    logic [256:0] data_reg, data_next;

    assign a_lo = s_axis_tdata[127:0];
    assign a_hi = s_axis_tdata[255:128];
    assign b_lo = s_axis_tdata[383:256];
    assign b_hi = s_axis_tdata[511:384];
    assign ctrl = '{op: s_axis_tdata[524:520], imm: s_axis_tdata[519:512],
                    elog: s_axis_tdata[526:525], wide: s_axis_tdata[527]};

    svpu_lane u_lane0 (.lane_idx(1'b0), .ctrl(ctrl), .a(a_lo), .b(b_lo),
        .a_full_lo(a_lo), .a_full_hi(a_hi), .b_full_lo(b_lo), .b_full_hi(b_hi),
        .r(r_lo));
    svpu_lane u_lane1 (.lane_idx(1'b1), .ctrl(ctrl), .a(a_hi), .b(b_hi),
        .a_full_lo(a_lo), .a_full_hi(a_hi), .b_full_lo(b_lo), .b_full_hi(b_hi),
        .r(r_hi));
    svpu_merge u_merge (.ctrl(ctrl), .r_lo(r_lo), .r_hi(r_hi), .res(res), .ok(ok));

    // Accept when the output slot is empty or is being drained
    assign s_axis_tready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
            data_next  = {ok, res};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, data_reg};

    `SVPU_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SVPU_ASSERT_NEXT(a_load, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `SVPU_ASSERT_IMPL(a_unh, m_axis_tvalid && !m_axis_tdata[256], m_axis_tdata[255:0] == 256'd0)
endmodule
`default_nettype wire

[verif/simd_vector_permute_unit_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the vector permute unit top level.
// Depends on svpu_pkg and simd_vector_permute_unit_top; predicts each permute request.
`default_nettype none
module simd_vector_permute_unit_top_test;
    import svpu_pkg::*;

    typedef struct {
        logic [255:0] a;
        logic [255:0] b;
        logic [7:0]   imm;
        logic [4:0]   op;
        logic [1:0]   elog;
        logic         wide;
    } perm_req_t;

    typedef struct {
        logic [255:0] vec;
        logic         handled;
    } perm_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [527:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;

    perm_req_t req_queue[$];
    perm_res_t expected_results[$];
    int        n_errors;
    int        idle_cycles;
    bit        stimulus_done;
    bit        hold_off_sink;
    bit        sender_paused;
    bit        in_fire;
    bit        out_fire;

    simd_vector_permute_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Record the handshakes at the rising edge for the falling-edge processes.
    always @(posedge clk)
    begin
        in_fire  = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
    end

    // Permute one request into its result vector and support flag.
    function automatic perm_res_t permute_vector(perm_req_t q);
        byte_t     av[32];
        byte_t     bv[32];
        byte_t     rv[32];
        perm_res_t res;
        int        es;
        int        lb;
        int        half;
        int        hb;
        int        sh;
        int        idx;
        int        d;
        int        c;
        int        sel;
        int        src;
        bit        ok;
        es = 1 << q.elog;
        ok = 1'b1;
        for (int i = 0; i < 32; i++)
        begin
            av[i] = q.a[8*i +: 8];
            bv[i] = q.b[8*i +: 8];
            rv[i] = 8'h00;
        end
        for (int l = 0; l < (q.wide ? 2 : 1); l++)
        begin
            lb = l * 16;
            case (q.op)
                OP_PSHUFB:
                    for (int j = 0; j < 16; j++)
                        rv[lb+j] = bv[lb+j][7] ? 8'h00 : av[lb + bv[lb+j][3:0]];
                OP_UNPCKL, OP_UNPCKH:
                begin
                    half = (16 / es) / 2;
                    hb = (q.op == OP_UNPCKH) ? half : 0;
                    for (int k = 0; k < half; k++)
                        for (int n = 0; n < es; n++)
                        begin
                            rv[lb + 2*k*es + n] = av[lb + (hb+k)*es + n];
                            rv[lb + (2*k+1)*es + n] = bv[lb + (hb+k)*es + n];
                        end
                end
                OP_PSHUFD:
                    for (int j = 0; j < 4; j++)
                        for (int n = 0; n < 4; n++)
                            rv[lb + 4*j + n] = av[lb + 4*((q.imm >> (2*j)) & 3) + n];
                OP_PSHUFLW:
                begin
                    for (int j = 0; j < 4; j++)
                        for (int n = 0; n < 2; n++)
                            rv[lb + 2*j + n] = av[lb + 2*((q.imm >> (2*j)) & 3) + n];
                    for (int n = 8; n < 16; n++)
                        rv[lb+n] = av[lb+n];
                end
                OP_PSHUFHW:
                begin
                    for (int n = 0; n < 8; n++)
                        rv[lb+n] = av[lb+n];
                    for (int j = 0; j < 4; j++)
                        for (int n = 0; n < 2; n++)
                            rv[lb + 8 + 2*j + n] = av[lb + 8 + 2*((q.imm >> (2*j)) & 3) + n];
                end
                OP_SHUFPS:
                    for (int n = 0; n < 4; n++)
                    begin
                        rv[lb+n]    = av[lb + 4*(q.imm & 3) + n];
                        rv[lb+4+n]  = av[lb + 4*((q.imm >> 2) & 3) + n];
                        rv[lb+8+n]  = bv[lb + 4*((q.imm >> 4) & 3) + n];
                        rv[lb+12+n] = bv[lb + 4*((q.imm >> 6) & 3) + n];
                    end
                OP_SHUFPD:
                    for (int n = 0; n < 8; n++)
                    begin
                        rv[lb+n]   = av[lb + 8*q.imm[2*l] + n];
                        rv[lb+8+n] = bv[lb + 8*q.imm[2*l+1] + n];
                    end
                OP_PALIGNR:
                begin
                    sh = (q.imm > MAX_SHIFT) ? 32 : q.imm;
                    for (int j = 0; j < 16; j++)
                    begin
                        idx = j + sh;
                        if (idx < 16)
                            rv[lb+j] = bv[lb+idx];
                        else if (idx < 32)
                            rv[lb+j] = av[lb+idx-16];
                        else
                            rv[lb+j] = 8'h00;
                    end
                end
                OP_BLENDD:
                    for (int j = 0; j < 4; j++)
                    begin
                        d = l*4 + j;
                        for (int n = 0; n < 4; n++)
                            rv[4*d+n] = q.imm[d] ? bv[4*d+n] : av[4*d+n];
                    end
                OP_PERM2F:
                    if (!q.wide)
                        ok = 1'b0;
                    else
                    begin
                        c = (q.imm >> (4*l)) & 4'hF;
                        if (!c[3])
                            for (int n = 0; n < 16; n++)
                                rv[lb+n] = (c[1] == 1'b0) ? av[c[0]*16 + n] : bv[c[0]*16 + n];
                    end
                OP_MOVDDUP:
                    for (int n = 0; n < 8; n++)
                    begin
                        rv[lb+n]   = av[lb+n];
                        rv[lb+8+n] = av[lb+n];
                    end
                OP_MOVSHDUP, OP_MOVSLDUP:
                    for (int k = 0; k < 2; k++)
                    begin
                        src = lb + 8*k + ((q.op == OP_MOVSHDUP) ? 4 : 0);
                        for (int n = 0; n < 4; n++)
                        begin
                            rv[lb + 8*k + n]     = av[src+n];
                            rv[lb + 8*k + 4 + n] = av[src+n];
                        end
                    end
                OP_PSHUFW:
                    if (q.wide)
                        ok = 1'b0;
                    else
                        for (int j = 0; j < 4; j++)
                            for (int n = 0; n < 2; n++)
                                rv[2*j+n] = av[2*((q.imm >> (2*j)) & 3) + n];
                OP_BCAST:
                    for (int j = 0; j < 16; j++)
                        rv[lb+j] = av[j % es];
                OP_PERMD:
                    if (!q.wide)
                        ok = 1'b0;
                    else
                        for (int j = 0; j < 4; j++)
                        begin
                            d = l*4 + j;
                            sel = av[4*d] & 7;
                            for (int n = 0; n < 4; n++)
                                rv[4*d+n] = bv[4*sel+n];
                        end
                default:
                    ok = 1'b0;
            endcase
        end
        res.vec = '0;
        if (ok)
            for (int i = 0; i < 32; i++)
                res.vec[8*i +: 8] = rv[i];
        res.handled = ok;
        return res;
    endfunction

    function automatic logic [255:0] rand_vec();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    function automatic perm_req_t rand_req();
        perm_req_t q;
        int        pick;
        q.a = rand_vec();
        q.b = rand_vec();
        pick = $urandom_range(0, 9);
        // bias the data towards all-zero and all-one words now and then
        if (pick == 0)
            q.a = '1;
        else if (pick == 1)
            q.b = '0;
        q.imm = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            q.imm = 8'($urandom_range(28, 36));
        // mostly legal codes, some unsupported ones
        q.op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
        q.elog = 2'($urandom_range(0, 3));
        q.wide = 1'($urandom_range(0, 1));
        return q;
    endfunction

    // Driver: present queued requests at the falling edge with random gaps.
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
    end

    int src_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                expected_results.push_back(permute_vector(req_queue.pop_front()));
                src_gap = $urandom_range(0, 13);
                if ($urandom_range(0, 2) == 0)
                    src_gap = 0;
            end
            if (s_axis_tvalid && !in_fire)
                ;   // hold the transaction until it is taken
            else if (src_gap > 0 || sender_paused || req_queue.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (src_gap > 0)
                    src_gap--;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {req_queue[0].wide, req_queue[0].elog, req_queue[0].op,
                                  req_queue[0].imm, req_queue[0].b, req_queue[0].a};
            end
        end
    end

    // Receiver: random ready, with one long hold-off on request.
    int sink_gap;
    initial
        m_axis_tready = 1'b0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                sink_gap = $urandom_range(0, 13);
            if (hold_off_sink)
                m_axis_tready <= 1'b0;
            else if (sink_gap > 0 && $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: sample results at the rising edge and compare.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                n_errors++;
            end
            else
            begin
                perm_res_t e;
                e = expected_results.pop_front();
                for (int w = 0; w < 4; w++)
                    if (m_axis_tdata[64*w +: 64] !== e.vec[64*w +: 64])
                    begin
                        $display("%0t: res_w%0d expected %h actual %h", $realtime, w,
                                 e.vec[64*w +: 64], m_axis_tdata[64*w +: 64]);
                        n_errors++;
                    end
                if (m_axis_tdata[256] !== e.handled)
                begin
                    $display("%0t: handled expected %b actual %b", $realtime, e.handled,
                             m_axis_tdata[256]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic perm_req_t make_req(logic [4:0] op, logic [7:0] imm, logic [1:0] elog,
                                           logic wide);
        perm_req_t q;
        q.a = rand_vec();
        q.b = rand_vec();
        q.op = op;
        q.imm = imm;
        q.elog = elog;
        q.wide = wide;
        return q;
    endfunction

    initial
    begin
        perm_req_t q;
        n_errors = 0;
        idle_cycles = 0;
        src_gap = 0;
        sink_gap = 0;
        stimulus_done = 0;
        hold_off_sink = 0;
        sender_paused = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation once, in alternating widths, plus corner cases.
        for (int o = 0; o <= 16; o++)
            req_queue.push_back(make_req(5'(o), 8'($urandom_range(0, 255)), 2'(o % 4),
                                         1'(o % 2)));
        q = make_req(OP_PSHUFB, 8'h00, 2'd0, 1'b1);
        q.b = {32{8'h8F}};
        req_queue.push_back(q);
        req_queue.push_back(make_req(OP_PALIGNR, 8'd255, 2'd0, 1'b1));
        req_queue.push_back(make_req(OP_PALIGNR, 8'd31, 2'd0, 1'b0));
        req_queue.push_back(make_req(OP_PERM2F, 8'h8C, 2'd0, 1'b1));
        req_queue.push_back(make_req(OP_PERM2F, 8'h00, 2'd0, 1'b0));
        req_queue.push_back(make_req(OP_PSHUFW, 8'hE4, 2'd0, 1'b1));
        req_queue.push_back(make_req(5'd31, 8'hFF, 2'd3, 1'b1));
        q = make_req(OP_BCAST, 8'h00, 2'd3, 1'b1);
        q.a = '1;
        req_queue.push_back(q);

        // Random: part one, with a long receiver hold-off partway.
        for (int i = 0; i < 900; i++)
            req_queue.push_back(rand_req());
        wait (req_queue.size() < 800);
        @(negedge clk);
        hold_off_sink = 1;
        repeat (60) @(negedge clk);
        hold_off_sink = 0;
        wait (req_queue.size() == 0);

        // Pause the sender until everything has drained.
        sender_paused = 1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        repeat (3) @(negedge clk);
        sender_paused = 0;

        for (int i = 0; i < 1000; i++)
            req_queue.push_back(rand_req());
        wait (req_queue.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (5) @(posedge clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
